/* hw/rtl/csfc_pkg.sv */
`default_nettype none

package csfc_pkg;

	localparam int unsigned ADDR_W  = 4;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned INDEX_W = 17;

	localparam logic [7:0]  SYNC_FIRST_RST  = 8'hC4;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'h03;
	localparam logic [15:0] BODY_LENGTH_RST = 16'd252;

	localparam logic [23:0] CRC_INIT = 24'h7FFA00;
	// 0x8005 sits in bits 23:8; bit 24 of the full constant is the top bit being dropped
	localparam logic [23:0] CRC_POLY = 24'h800500;

	// index of the header byte that ends the length field; the last frame byte sits at body_length + HDR_LEN
	localparam int unsigned HDR_LEN = 4;

	typedef enum logic [1:0] {
		REG_SYNC_FIRST  = 2'd0,
		REG_SYNC_SECOND = 2'd1,
		REG_BODY_LENGTH = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		STAT_OK     = 3'd0,
		STAT_SHORT  = 3'd1,
		STAT_SYNC   = 3'd2,
		STAT_LENGTH = 3'd3,
		STAT_CRC    = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [15:0] body_length;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
		logic       buffer_end;
	} item_t;

	typedef struct packed {
		logic        frame_ok;
		status_t     status;
		logic [15:0] crc_value;
	} result_t;

	// one byte through the shift CRC: OR into the low byte, then eight shift/reduce steps
	function automatic logic [23:0] crc_feed(input logic [23:0] crc, input logic [7:0] b);
		logic [23:0] r;
		r = {crc[23:8], crc[7:0] | b};
		for (int k = 0; k < 8; k++) begin
			if (r[23]) begin
				r = {r[22:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[22:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/csfc_if.sv */
`default_nettype none

interface csfc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;
	logic       buffer_end;

	modport source (output valid, output data_byte, output frame_start, output buffer_end,
		input ready);
	modport sink (input valid, input data_byte, input frame_start, input buffer_end,
		output ready);
endinterface

interface csfc_verdict_if;
	logic        valid;
	logic        ready;
	logic        frame_ok;
	logic [2:0]  status;
	logic [15:0] crc_value;

	modport source (output valid, output frame_ok, output status, output crc_value,
		input ready);
	modport sink (input valid, input frame_ok, input status, input crc_value,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/csfc_apb_regs.sv */
`default_nettype none

module csfc_apb_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [csfc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [csfc_pkg::DATA_W-1:0] pwdata,
	output logic      [csfc_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	output csfc_pkg::cfg_t                   cfg
);

	csfc_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= csfc_pkg::SYNC_FIRST_RST;
			cfg_q.sync_second <= csfc_pkg::SYNC_SECOND_RST;
			cfg_q.body_length <= csfc_pkg::BODY_LENGTH_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				csfc_pkg::REG_SYNC_FIRST:  cfg_q.sync_first  <= pwdata[7:0];
				csfc_pkg::REG_SYNC_SECOND: cfg_q.sync_second <= pwdata[7:0];
				csfc_pkg::REG_BODY_LENGTH: cfg_q.body_length <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			csfc_pkg::REG_SYNC_FIRST:  prdata = {24'd0, cfg_q.sync_first};
			csfc_pkg::REG_SYNC_SECOND: prdata = {24'd0, cfg_q.sync_second};
			csfc_pkg::REG_BODY_LENGTH: prdata = {16'd0, cfg_q.body_length};
			default:                   prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/csfc_core.sv */
`default_nettype none

// Frame state and per-byte check. State is written only when the staged byte moves on.
module csfc_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire csfc_pkg::cfg_t      cfg,
	input  wire csfc_pkg::item_t     item,
	input  wire logic                advance,
	output logic                     emit,
	output csfc_pkg::result_t        result
);

	logic [csfc_pkg::INDEX_W-1:0] byte_index_q;
	logic [23:0]                  crc_q;
	logic [15:0]                  length_field_q;
	logic                         sync_bad_q;
	logic                         frame_active_q;

	logic                         act;
	logic [csfc_pkg::INDEX_W-1:0] idx;
	logic [23:0]                  crc_cur;
	logic [23:0]                  crc_nxt;
	logic [15:0]                  len_cur;
	logic [15:0]                  len_nxt;
	logic                         sbad_cur;
	logic                         sbad_nxt;
	logic [csfc_pkg::INDEX_W-1:0] last_idx;
	logic                         at_last;

	// frame_start restarts from the reset values
	assign act      = item.frame_start || frame_active_q;
	assign idx      = item.frame_start ? '0 : byte_index_q;
	assign crc_cur  = item.frame_start ? csfc_pkg::CRC_INIT : crc_q;
	assign len_cur  = item.frame_start ? 16'd0 : length_field_q;
	assign sbad_cur = item.frame_start ? 1'b0 : sync_bad_q;

	assign last_idx = {1'b0, cfg.body_length} + csfc_pkg::INDEX_W'(csfc_pkg::HDR_LEN);
	assign at_last  = (idx >= last_idx);

	always_comb begin
		crc_nxt  = crc_cur;
		len_nxt  = len_cur;
		sbad_nxt = sbad_cur;
		if (idx == csfc_pkg::INDEX_W'(0)) begin
			sbad_nxt = sbad_cur || (item.data_byte != cfg.sync_first);
		end else if (idx == csfc_pkg::INDEX_W'(1)) begin
			sbad_nxt = sbad_cur || (item.data_byte != cfg.sync_second);
		end else begin
			crc_nxt = csfc_pkg::crc_feed(crc_cur, item.data_byte);
			if (idx == csfc_pkg::INDEX_W'(3)) begin
				len_nxt = {len_cur[15:8], item.data_byte};
			end else if (idx == csfc_pkg::INDEX_W'(4)) begin
				len_nxt = {item.data_byte, len_cur[7:0]};
			end
		end
	end

	assign emit = act && (at_last || item.buffer_end);

	always_comb begin
		result.crc_value = crc_nxt[23:8];
		priority if (!at_last) begin
			result.status = csfc_pkg::STAT_SHORT;
		end else if (sbad_nxt) begin
			result.status = csfc_pkg::STAT_SYNC;
		end else if (len_nxt != cfg.body_length) begin
			result.status = csfc_pkg::STAT_LENGTH;
		end else if (crc_nxt[23:8] != 16'd0) begin
			result.status = csfc_pkg::STAT_CRC;
		end else begin
			result.status = csfc_pkg::STAT_OK;
		end
		result.frame_ok = (result.status == csfc_pkg::STAT_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q   <= '0;
			crc_q          <= csfc_pkg::CRC_INIT;
			length_field_q <= '0;
			sync_bad_q     <= 1'b0;
			frame_active_q <= 1'b0;
		end else if (advance && act) begin
			byte_index_q   <= idx + csfc_pkg::INDEX_W'(1);
			crc_q          <= crc_nxt;
			length_field_q <= len_nxt;
			sync_bad_q     <= sbad_nxt;
			frame_active_q <= !emit;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/crc16_sync_frame_checker.sv */
// Streaming checker for one framed packet, one byte per transfer on "bytes". A transfer with
// frame_start begins a frame (abandoning any frame in progress without a verdict); bytes outside
// a frame are dropped. Bytes 0 and 1 are compared to sync_first/sync_second, bytes 3 and 4 form a
// little-endian length that must equal body_length, and a 24-bit shift CRC (0x8005 in bits 23:8,
// seeded 0x7FFA00) runs from byte 2 to the last byte, index body_length + 4. One verdict transfer
// on "verdict" follows the last byte, or the byte marked buffer_end if the frame is cut short;
// status priority is short, sync, length, CRC, and crc_value always shows CRC bits 23:8.
// Rate: one byte per clock, sustained while no held verdict is stalled by verdict.ready. A byte
// is held in the input stage register and its verdict, if any, is then loaded into the result
// register. The byte-wide CRC update, compares and status select sit in one combinational
// step between those registers. Config registers sit on an APB port at 0x0, 0x4 and 0x8 with no
// wait states; write them only while no frame is in flight.

`default_nettype none

module crc16_sync_frame_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	csfc_byte_if.sink                        bytes,
	csfc_verdict_if.source                   verdict,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [csfc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [csfc_pkg::DATA_W-1:0] pwdata,
	output logic      [csfc_pkg::DATA_W-1:0] prdata,
	output logic                             pready
);

	csfc_pkg::cfg_t    cfg;

	// input stage
	csfc_pkg::item_t   item_s1;
	logic              valid_s1;

	// result register
	csfc_pkg::result_t result_q;
	logic              result_valid_q;

	csfc_pkg::result_t result;
	logic              emit;
	logic              advance;

	csfc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// staged byte moves on whenever the result register is free or being drained this cycle
	assign advance     = valid_s1 && (!result_valid_q || verdict.ready);
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			item_s1.data_byte   <= bytes.data_byte;
			item_s1.frame_start <= bytes.frame_start;
			item_s1.buffer_end  <= bytes.buffer_end;
		end
	end

	csfc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.emit    (emit),
		.result  (result)
	);

	// verdict register: loaded by a verdict-producing byte, cleared on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && emit) begin
			result_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= result;
		end
	end

	assign verdict.valid     = result_valid_q;
	assign verdict.frame_ok  = result_q.frame_ok;
	assign verdict.status    = result_q.status;
	assign verdict.crc_value = result_q.crc_value;

	// a pass verdict always carries a zero CRC remainder
	assert property (@(posedge clk) disable iff (!arst_n)
		(verdict.valid && (verdict.status == csfc_pkg::STAT_OK)) |-> (verdict.crc_value == 16'd0))
		else $error("pass verdict with nonzero CRC");

	// frame_ok and status agree
	assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid |-> (verdict.frame_ok == (verdict.status == csfc_pkg::STAT_OK)))
		else $error("frame_ok disagrees with status");

	// a verdict produced by the staged byte shows up next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> verdict.valid)
		else $error("verdict lost");

	// a pending verdict is never overwritten while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !verdict.ready) |-> !advance)
		else $error("staged byte advanced over a stalled verdict");

endmodule

`default_nettype wire

/* bench/crc16_sync_frame_checker_test.sv */
`default_nettype none

module crc16_sync_frame_checker_test;
	timeunit 1ns;
	timeprecision 1ps;

	import csfc_pkg::*;

	// cycles without any byte, verdict or register transfer before we give up
	localparam int WATCHDOG_LIMIT = 3000;
	// rough number of frame bytes to push through before stopping
	localparam int ITEM_GOAL = 650;
	// last stretch of the run goes without any idling on either side
	localparam int CALM_TAIL = 90;
	localparam logic [15:0] BIG_BODY = 16'd65530;
	// only frames up to this size are built whole; larger bodies are always cut short
	localparam int WHOLE_FRAME_MAX = 64;
	localparam int CUT_MAX = 40;
	// settling margin after the last verdict is in
	localparam int SETTLE_CYCLES = 6;

	typedef enum int {
		FR_GOOD,
		FR_SYNC_ERR,
		FR_LEN_ERR,
		FR_CRC_ERR,
		FR_CUT,
		FR_DROP
	} frame_kind_t;

	// Tracks the checker's frame state and queues the verdict each byte should produce.
	class verdict_ledger;
		cfg_t        cfg;
		logic [16:0] index;
		logic [23:0] shifter;
		logic [15:0] length_seen;
		bit          sync_bad;
		bit          in_frame;
		result_t     verdicts_due[$];
		int          fails;

		function new();
			cfg.sync_first  = SYNC_FIRST_RST;
			cfg.sync_second = SYNC_SECOND_RST;
			cfg.body_length = BODY_LENGTH_RST;
			index       = '0;
			shifter     = CRC_INIT;
			length_seen = '0;
			sync_bad    = 1'b0;
			in_frame    = 1'b0;
			fails       = 0;
		endfunction

		// one byte into the 24-bit shift register; 25-bit view so the dropped top bit is visible
		static function logic [23:0] crc_shift(logic [23:0] r, logic [7:0] b);
			logic [24:0] acc;
			int k;
			acc = {1'b0, r | {16'h0000, b}};
			for (k = 0; k < 8; k++) begin
				acc = acc << 1;
				if (acc[24]) begin
					acc ^= 25'h1800500;
				end
			end
			return acc[23:0];
		endfunction

		function void set_reg(reg_index_t r, logic [15:0] v);
			case (r)
				REG_SYNC_FIRST: begin
					cfg.sync_first = v[7:0];
				end
				REG_SYNC_SECOND: begin
					cfg.sync_second = v[7:0];
				end
				default: begin
					cfg.body_length = v;
				end
			endcase
		endfunction

		function void absorb_byte(logic [7:0] b, logic start, logic buf_end);
			logic [16:0] last;
			result_t v;
			if (start) begin
				index       = '0;
				shifter     = CRC_INIT;
				length_seen = '0;
				sync_bad    = 1'b0;
				in_frame    = 1'b1;
			end
			if (!in_frame) begin
				return;
			end
			if (index == 17'd0) begin
				if (b != cfg.sync_first) sync_bad = 1'b1;
			end else if (index == 17'd1) begin
				if (b != cfg.sync_second) sync_bad = 1'b1;
			end else begin
				shifter = crc_shift(shifter, b);
				if (index == 17'd3) begin
					length_seen[7:0] = b;
				end else if (index == 17'd4) begin
					length_seen[15:8] = b;
				end
			end
			last = {1'b0, cfg.body_length} + 17'd4;
			if (index >= last) begin
				if (sync_bad) begin
					v.status = STAT_SYNC;
				end else if (length_seen != cfg.body_length) begin
					v.status = STAT_LENGTH;
				end else if (shifter[23:8] != 16'h0000) begin
					v.status = STAT_CRC;
				end else begin
					v.status = STAT_OK;
				end
			end else if (buf_end) begin
				v.status = STAT_SHORT;
			end else begin
				index = index + 17'd1;
				return;
			end
			v.frame_ok  = (v.status == STAT_OK);
			v.crc_value = shifter[23:8];
			verdicts_due.push_back(v);
			in_frame = 1'b0;
		endfunction

		task report(string what);
			fails++;
			$display("%0t ns: mismatch: %s", $time, what);
		endtask

		task check_verdict(logic ok, logic [2:0] st, logic [15:0] crc);
			result_t w;
			if (verdicts_due.size() == 0) begin
				report($sformatf("unexpected verdict ok=%0b status=%0d crc=%04h", ok, st, crc));
				return;
			end
			w = verdicts_due.pop_front();
			if (ok !== w.frame_ok) begin
				report($sformatf("frame_ok %0b, want %0b", ok, w.frame_ok));
			end
			if (st !== w.status) begin
				report($sformatf("status %0d, want %0d (%s)", st, w.status, w.status.name()));
			end
			if (crc !== w.crc_value) begin
				report($sformatf("crc_value %04h, want %04h", crc, w.crc_value));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	csfc_byte_if    byte_ch ();
	csfc_verdict_if verdict_ch ();

	verdict_ledger ledger;

	// stimulus shaping, owned by the main sequence
	bit calm;
	int gap_odds;
	int sent;

	// sink-side stall bookkeeping
	int stall_left;
	int run_left;

	int idle_cycles;

	crc16_sync_frame_checker dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.verdict (verdict_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Verdict sink: bursts of stall between runs of ready, some of them long.
	// Always ready once the run reaches its calm tail.
	always @(negedge clk) begin
		if (calm) begin
			verdict_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			verdict_ch.ready <= 1'b0;
			stall_left--;
		end else if (run_left > 0) begin
			verdict_ch.ready <= 1'b1;
			run_left--;
		end else begin
			verdict_ch.ready <= 1'b0;
			stall_left = $urandom_range(1, 13) - 1;
			run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
		end
	end

	// Verdict monitor: every accepted transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin
			ledger.check_verdict(verdict_ch.frame_ok, verdict_ch.status, verdict_ch.crc_value);
		end
	end

	// Watchdog: any transfer on either channel or the register port counts as progress.
	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (verdict_ch.valid && verdict_ch.ready) || psel) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("crc16_sync_frame_checker_test: FAIL");
			$finish;
		end
	end

	// Push one byte. Called and returns at a falling edge; may idle the source first.
	task automatic push_byte(logic [7:0] b, logic start, logic buf_end);
		if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.data_byte   <= b;
		byte_ch.frame_start <= start;
		byte_ch.buffer_end  <= buf_end;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
		ledger.absorb_byte(b, start, buf_end);
		@(negedge clk);
	endtask

	// Stop the byte stream and wait until every verdict is in, plus pipeline margin
	// in case a byte that causes no verdict is still inside the block.
	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (ledger.verdicts_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// APB write followed by a read-back of the same register; ends at a falling edge.
	task automatic cfg_write(reg_index_t r, logic [15:0] v);
		logic [15:0] mask;
		logic [DATA_W-1:0] got;
		mask = (r == REG_BODY_LENGTH) ? 16'hFFFF : 16'h00FF;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= {16'h0000, v & mask};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		ledger.set_reg(r, v & mask);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		got = prdata;
		if ((got[15:0] & mask) !== (v & mask)) begin
			ledger.report($sformatf("%s reads back %0h, want %0h", r.name(), got, v & mask));
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(logic [7:0] first, logic [7:0] second, logic [15:0] body);
		settle();
		cfg_write(REG_SYNC_FIRST, {8'h00, first});
		cfg_write(REG_SYNC_SECOND, {8'h00, second});
		cfg_write(REG_BODY_LENGTH, body);
	endtask

	// Build one frame for the current settings, apply the requested fault and send it.
	// Good frames carry a CRC trailer chosen so the register drains to zero; that needs
	// a body of at least two bytes so the trailer clears the length field.
	task automatic send_frame(frame_kind_t kind);
		logic [7:0]  fb[$];
		logic [15:0] len;
		logic [23:0] acc;
		int n, limit, cut, pos, i;
		bit tail_end;
		len = ledger.cfg.body_length;
		n = int'(len) + 5;
		limit = (n > WHOLE_FRAME_MAX) ? WHOLE_FRAME_MAX : n;
		fb.push_back(ledger.cfg.sync_first);
		fb.push_back(ledger.cfg.sync_second);
		fb.push_back(8'($urandom));
		fb.push_back(len[7:0]);
		fb.push_back(len[15:8]);
		while (fb.size() < limit) fb.push_back(8'($urandom));

		if (kind == FR_SYNC_ERR) begin
			pos = $urandom_range(0, 1);
			fb[pos] ^= 8'($urandom_range(1, 255));
		end
		// length fault goes in before the trailer, so only the length check trips
		if (kind == FR_LEN_ERR) begin
			pos = $urandom_range(3, 4);
			fb[pos] ^= 8'($urandom_range(1, 255));
		end
		if (n <= WHOLE_FRAME_MAX && len >= 16'd2) begin
			acc = CRC_INIT;
			for (i = 2; i < n - 2; i++) acc = verdict_ledger::crc_shift(acc, fb[i]);
			acc = verdict_ledger::crc_shift(verdict_ledger::crc_shift(acc, 8'h00), 8'h00);
			fb[n - 2] = acc[23:16];
			fb[n - 1] = acc[15:8];
		end
		// corrupt a CRC-covered byte outside the length field
		if (kind == FR_CRC_ERR) begin
			pos = $urandom_range(0, limit - 5);
			pos = (pos == 0) ? 2 : pos + 4;
			fb[pos] ^= 8'($urandom_range(1, 255));
		end

		if (kind == FR_CUT || kind == FR_DROP) begin
			cut = $urandom_range(1, (n - 1 < CUT_MAX) ? n - 1 : CUT_MAX);
		end else begin
			cut = n;
		end
		// a complete frame may also carry the buffer-end mark on its last byte
		tail_end = (kind == FR_CUT) || ($urandom_range(0, 3) == 0 && kind != FR_DROP);
		for (i = 0; i < cut; i++) begin
			push_byte(fb[i], i == 0, tail_end && i == cut - 1);
		end
		sent += cut;
	endtask

	function automatic frame_kind_t pick_kind(logic [15:0] body);
		int r;
		r = $urandom_range(0, 99);
		if (int'(body) + 5 > WHOLE_FRAME_MAX) begin
			return (r < 60) ? FR_CUT : FR_DROP;
		end
		if (r < 40) return FR_GOOD;
		if (r < 50) return FR_CRC_ERR;
		if (r < 58) return FR_LEN_ERR;
		if (r < 66) return FR_SYNC_ERR;
		if (r < 82) return FR_CUT;
		return FR_DROP;
	endfunction

	function automatic logic [7:0] pick_sync();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] body;
		int ph, stop;
		ledger = new();
		arst_n = 1'b0;
		byte_ch.valid       = 1'b0;
		byte_ch.data_byte   = 8'h00;
		byte_ch.frame_start = 1'b0;
		byte_ch.buffer_end  = 1'b0;
		verdict_ch.ready = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		calm = 1'b0;
		gap_odds = 0;
		sent = 0;
		stall_left = 0;
		run_left = 0;
		idle_cycles = 0;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// --- directed: reset settings ---
		// bytes outside a frame are dropped, buffer_end included
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b1);
		// start and buffer end on the same byte: short at once
		push_byte(8'hC4, 1'b1, 1'b1);
		// restart mid-frame abandons the first frame; the new one is cut short
		push_byte(8'hC4, 1'b1, 1'b0);
		push_byte(8'h03, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b1, 1'b1);

		// --- directed: empty body, sync extremes ---
		set_config(8'h00, 8'hFF, 16'd0);
		send_frame(FR_GOOD);
		send_frame(FR_SYNC_ERR);

		// --- directed: smallest body that can carry a clean CRC trailer ---
		set_config(8'hFF, 8'h00, 16'd2);
		send_frame(FR_GOOD);
		send_frame(FR_CRC_ERR);

		// --- random phases, each under its own settings ---
		ph = 0;
		while (sent < ITEM_GOAL) begin
			gap_odds = $urandom_range(2, 10);
			if (ph == 1) begin
				body = BIG_BODY;
			end else begin
				case ($urandom_range(0, 7))
					0: body = 16'd0;
					1: body = 16'd1;
					2, 3: body = 16'($urandom_range(13, 40));
					default: body = 16'($urandom_range(2, 12));
				endcase
			end
			if (ph == 0) begin
				set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, body);
			end else begin
				set_config(pick_sync(), pick_sync(), body);
			end
			stop = sent + $urandom_range(45, 80);
			while (sent < stop && sent < ITEM_GOAL) begin
				calm = (sent >= ITEM_GOAL - CALM_TAIL);
				send_frame(pick_kind(body));
				// stray bytes between frames; dropped unless a frame was left open
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 3)) begin
						push_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
					end
				end
			end
			ph++;
		end

		settle();
		if (ledger.fails == 0) begin
			$display("crc16_sync_frame_checker_test: PASS");
		end else begin
			$display("crc16_sync_frame_checker_test: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
